// ----- src/pcst_pkg.sv -----
// Package with types and constants for the periodic callback slot timer.
`timescale 1ns / 1ps

package pcst_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int HANDLE_W      = 8;
    localparam int PERIOD_W      = 16;
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_CHECK    = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_REFUSED    = 2'd1,
        KIND_FIRED      = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
    } t_slot;

    // Control handed from the sequencer to the slot operator.
    typedef struct packed {
        t_cmd                cmd;
        logic                claim_ok;
        logic                fire_ok;
        logic [HANDLE_W-1:0] new_handle;
        logic [PERIOD_W-1:0] period;
    } t_op_ctl;

    // What the slot operator did to the slot at the head of the ring.
    typedef struct packed {
        t_slot slot;
        logic  claim;
        logic  fire;
    } t_op_res;

endpackage

// ----- src/pcst_if.sv -----
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps

interface pcst_cmd_if;
    import pcst_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PERIOD_W-1:0] period;

    modport source (output valid, command, period, input ready);
    modport sink   (input valid, command, period, output ready);
endinterface

interface pcst_res_if;
    import pcst_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic                last;

    modport source (output valid, kind, handle, last, input ready);
    modport sink   (input valid, kind, handle, last, output ready);
endinterface

// ----- src/pcst_cell.sv -----
// One slot cell of the rotating ring: holds a slot and takes its neighbor's slot on a shift.
`timescale 1ns / 1ps

module pcst_cell
    import pcst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- src/pcst_slot_op.sv -----
// Applies the current command to the slot leaving the head of the ring.
`timescale 1ns / 1ps

module pcst_slot_op
    import pcst_pkg::*;
(
    input  t_slot   i_slot,
    input  t_op_ctl i_ctl,
    output t_op_res o_res
);

    always_comb begin
        o_res.slot  = i_slot;
        o_res.claim = 1'b0;
        o_res.fire  = 1'b0;
        case (i_ctl.cmd)
            CMD_TICK: begin
                if (i_slot.handle != '0 && i_slot.count != '0) begin
                    o_res.slot.count = i_slot.count - PERIOD_W'(1);
                end
            end
            CMD_REGISTER: begin
                // Only the first free slot of the pass is claimed.
                if (i_slot.handle == '0 && i_ctl.claim_ok) begin
                    o_res.slot.handle = i_ctl.new_handle;
                    o_res.slot.period = i_ctl.period;
                    o_res.slot.count  = i_ctl.period;
                    o_res.claim       = 1'b1;
                end
            end
            CMD_CHECK: begin
                if (i_slot.handle != '0 && i_slot.count == '0 && i_ctl.fire_ok) begin
                    o_res.slot.count = i_slot.period;
                    o_res.fire       = 1'b1;
                end
            end
            default: begin
                o_res.slot = i_slot;
            end
        endcase
    end

endmodule

// ----- src/periodic_callback_slot_timer.sv -----
// Top level of the periodic callback slot timer: slot ring, sequencer and result register.
//
//   Channel  | Dir | Handshake          | Word
//   i_cmd    | in  | valid / ready      | command[1:0], period[15:0]
//   o_res    | out | valid / ready      | kind[1:0], handle[7:0], last
//
// Every command word (tick, register, check) rotates the whole slot ring once,
// one slot per cycle while the result port does not stall it, then returns to
// idle: the idle state accepts it, the scan state rotates every slot through
// the single slot operator, and the finishing state sends any last result word.
// Command code 3 is accepted and dropped without a scan.
// Reset (synchronous, active low) clears every slot and the handle counter at once.
// A stalled result port holds the rotation only when a new result word has to
// be pushed while the result register is still full; ticks never stall.

`timescale 1ns / 1ps

module periodic_callback_slot_timer
    import pcst_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcst_cmd_if.sink   i_cmd,
    pcst_res_if.source o_res
);

    localparam int STEP_W = $clog2(NUM_SLOTS + 1);
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    // Slot ring. Cell k takes from cell k+1; the last cell takes the head
    // slot after the slot operator has worked on it.
    t_slot   w_cell_q [NUM_SLOTS];
    t_slot   w_cell_d [NUM_SLOTS];
    logic    w_shift;
    t_op_ctl w_ctl;
    t_op_res w_op;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_ring
            if (g == NUM_SLOTS - 1) begin : g_tail
                assign w_cell_d[g] = w_op.slot;
            end else begin : g_mid
                assign w_cell_d[g] = w_cell_q[g+1];
            end
            pcst_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_cell_d[g]),
                .o_slot  (w_cell_q[g])
            );
        end
    endgenerate

    pcst_slot_op u_op (
        .i_slot (w_cell_q[0]),
        .i_ctl  (w_ctl),
        .o_res  (w_op)
    );

    // Sequencer state.
    t_state              r_state,       n_state;
    t_cmd                r_cmd,         n_cmd;
    logic [PERIOD_W-1:0] r_period,      n_period;
    logic [STEP_W-1:0]   r_step,        n_step;
    logic [NRES_W-1:0]   r_nres,        n_nres;
    logic                r_claimed,     n_claimed;
    logic [HANDLE_W-1:0] r_last_handle, n_last_handle;
    logic                r_pend_valid,  n_pend_valid;
    logic [HANDLE_W-1:0] r_pend_handle, n_pend_handle;

    // Result register.
    logic                r_out_valid,  n_out_valid;
    t_kind               r_out_kind,   n_out_kind;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic                r_out_last,   n_out_last;

    logic                w_can_push;
    logic                w_push;
    logic [HANDLE_W-1:0] w_new_handle;

    // Handles run 1..255 and wrap back to 1, never 0.
    always_comb begin
        w_new_handle = r_last_handle + HANDLE_W'(1);
        if (w_new_handle == '0) begin
            w_new_handle = HANDLE_W'(1);
        end
    end

    assign w_ctl.cmd        = r_cmd;
    assign w_ctl.claim_ok   = !r_claimed;
    assign w_ctl.fire_ok    = (r_nres < NRES_W'(MAX_RESULTS));
    assign w_ctl.new_handle = w_new_handle;
    assign w_ctl.period     = r_period;

    assign w_can_push = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last_handle <= '0;
            r_out_valid   <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_claimed     <= 1'b0;
            r_nres        <= '0;
            r_step        <= '0;
        end else begin
            r_state       <= n_state;
            r_last_handle <= n_last_handle;
            r_out_valid   <= n_out_valid;
            r_pend_valid  <= n_pend_valid;
            r_claimed     <= n_claimed;
            r_nres        <= n_nres;
            r_step        <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_period      <= n_period;
        r_pend_handle <= n_pend_handle;
        r_out_kind    <= n_out_kind;
        r_out_handle  <= n_out_handle;
        r_out_last    <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_period      = r_period;
        n_step        = r_step;
        n_nres        = r_nres;
        n_claimed     = r_claimed;
        n_last_handle = r_last_handle;
        n_pend_valid  = r_pend_valid;
        n_pend_handle = r_pend_handle;
        n_out_kind    = r_out_kind;
        n_out_handle  = r_out_handle;
        n_out_last    = r_out_last;
        w_shift       = 1'b0;
        w_push        = 1'b0;
        i_cmd.ready   = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd        = t_cmd'(i_cmd.command);
                    n_period     = i_cmd.period;
                    n_step       = '0;
                    n_nres       = '0;
                    n_claimed    = 1'b0;
                    n_pend_valid = 1'b0;
                    if (i_cmd.command inside {CMD_TICK, CMD_REGISTER, CMD_CHECK}) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // A new fire with one already pending pushes the pending word
                // out, which needs room in the result register.
                if (!(w_op.fire && r_pend_valid && !w_can_push)) begin
                    w_shift = 1'b1;
                    n_step  = r_step + STEP_W'(1);
                    if (w_op.fire) begin
                        if (r_pend_valid) begin
                            w_push       = 1'b1;
                            n_out_kind   = KIND_FIRED;
                            n_out_handle = r_pend_handle;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_handle = w_cell_q[0].handle;
                        n_nres        = r_nres + NRES_W'(1);
                    end
                    if (w_op.claim) begin
                        n_claimed     = 1'b1;
                        n_last_handle = w_new_handle;
                    end
                    if (r_step == STEP_W'(NUM_SLOTS - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                case (r_cmd)
                    CMD_REGISTER: begin
                        if (w_can_push) begin
                            w_push       = 1'b1;
                            n_out_kind   = r_claimed ? KIND_REGISTERED : KIND_REFUSED;
                            n_out_handle = r_claimed ? r_last_handle : '0;
                            n_out_last   = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    CMD_CHECK: begin
                        if (!r_pend_valid) begin
                            n_state = S_IDLE;
                        end else if (w_can_push) begin
                            w_push       = 1'b1;
                            n_out_kind   = KIND_FIRED;
                            n_out_handle = r_pend_handle;
                            n_out_last   = 1'b1;
                            n_pend_valid = 1'b0;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.kind   = r_out_kind;
    assign o_res.handle = r_out_handle;
    assign o_res.last   = r_out_last;

    // A check never reports more slots than the result limit allows.
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("result count exceeds limit");

    // A register command claims at most one slot per pass.
    a_one_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && w_op.claim) |-> !r_claimed)
        else $error("second slot claimed in one pass");

    // A push during the scan always carries an earlier pending fire.
    a_scan_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_state == S_SCAN) |-> r_pend_valid && w_op.fire)
        else $error("scan push without pending fire");

    // The finishing state is reached only from a scan.
    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> $past(r_state) == S_SCAN)
        else $error("finishing state entered outside a scan");

    // The result register is never overwritten while a word waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || o_res.ready))
        else $error("result word overwritten");

endmodule
